/* rtl/core/ieps_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ieps_pkg;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_POLL  = 3'd1,
    PH_WDATA = 3'd2,
    PH_WPAGE = 3'd3,
    PH_RADDR = 3'd4,
    PH_RDATA = 3'd5
  } phase_t;

  localparam logic [2:0] OP_WBEGIN = 3'd0;
  localparam logic [2:0] OP_WDATA  = 3'd1;
  localparam logic [2:0] OP_RBEGIN = 3'd2;
  localparam logic [2:0] OP_ACK    = 3'd3;
  localparam logic [2:0] OP_BYTE   = 3'd4;

  localparam logic [3:0] SYM_START   = 4'd0;
  localparam logic [3:0] SYM_SEND    = 4'd1;
  localparam logic [3:0] SYM_RECV    = 4'd2;
  localparam logic [3:0] SYM_ACK     = 4'd3;
  localparam logic [3:0] SYM_NACK    = 4'd4;
  localparam logic [3:0] SYM_RELEASE = 4'd5;
  localparam logic [3:0] SYM_READ    = 4'd6;
  localparam logic [3:0] SYM_DONE    = 4'd7;
  localparam logic [3:0] SYM_REJECT  = 4'd8;

  localparam logic [7:0] DEV_WRITE = 8'hA0;
  localparam logic [7:0] DEV_READ  = 8'hA1;

  // One classified item: up to three symbols with their values.
  typedef struct packed {
    logic [1:0]  count;   // number of symbols minus one
    logic [3:0]  sym0;
    logic [7:0]  val0;
    logic [3:0]  sym1;
    logic [7:0]  val1;
    logic [3:0]  sym2;
    logic [7:0]  val2;
  } burst_t;

endpackage
`default_nettype wire

/* rtl/core/ieps_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module ieps_front import ieps_pkg::*; #(
  parameter int PAGE_BYTES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        take,
  input  wire logic [2:0]  op,
  input  wire logic [15:0] ee_addr,
  input  wire logic [7:0]  data,
  input  wire logic        last_byte,
  input  wire logic [15:0] read_count,
  input  wire logic        ack_bit,
  output burst_t           burst,
  output logic             has_burst
);

  function automatic int tz_of(int v);
    int n;
    n = 0;
    while (v > 1 && v[0] == 1'b0) begin
      v = v >> 1;
      n++;
    end
    return n;
  endfunction

  // inverse of an odd value modulo 2^16 by Newton iteration
  function automatic logic [15:0] inv16(int m);
    logic [15:0] x;
    logic [15:0] mm;
    mm = 16'(m);
    x  = mm;
    for (int i = 0; i < 4; i++) begin
      x = x * (16'd2 - mm * x);
    end
    return x;
  endfunction

  localparam logic [15:0] PMASK = 16'(PAGE_BYTES - 1);
  localparam int          PTZ   = tz_of(PAGE_BYTES);
  localparam int          PODD  = PAGE_BYTES >> PTZ;
  localparam logic [15:0] PLOW  = 16'((1 << PTZ) - 1);
  localparam logic [15:0] PINV  = inv16(PODD);
  localparam logic [15:0] PLIM  = 16'(65535 / PODD);

  phase_t      phase_r, phase_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [15:0] left_r, left_nxt;
  logic        reading_r, reading_nxt;
  logic [15:0] addr_inc;
  logic        page_end;

  assign addr_inc = addr_r + 16'd1;
  generate
    if ((PAGE_BYTES & (PAGE_BYTES - 1)) == 0) begin : g_pow2
      assign page_end = ((addr_inc & PMASK) == 16'd0);
    end else begin : g_npow2
      // divisible by the odd part when the product by its inverse stays in range
      logic [15:0] odd_prod;
      assign odd_prod = addr_inc * PINV;
      assign page_end = ((addr_inc & PLOW) == 16'd0) && (odd_prod <= PLIM);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      addr_r    <= 16'd0;
      left_r    <= 16'd0;
      reading_r <= 1'b0;
    end else if (take) begin
      phase_r   <= phase_nxt;
      addr_r    <= addr_nxt;
      left_r    <= left_nxt;
      reading_r <= reading_nxt;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    addr_nxt    = addr_r;
    left_nxt    = left_r;
    reading_nxt = reading_r;
    has_burst   = 1'b1;
    burst       = '0;
    burst.sym0  = SYM_REJECT;
    if (op == OP_WBEGIN && phase_r == PH_IDLE) begin
      addr_nxt = ee_addr; reading_nxt = 1'b0; phase_nxt = PH_POLL;
      burst.count = 2'd1; burst.sym0 = SYM_START;
      burst.sym1 = SYM_SEND; burst.val1 = DEV_WRITE;
    end else if (op == OP_RBEGIN && phase_r == PH_IDLE) begin
      addr_nxt = ee_addr; reading_nxt = 1'b1; phase_nxt = PH_POLL;
      left_nxt = (read_count == 16'd0) ? 16'd1 : read_count;
      burst.count = 2'd1; burst.sym0 = SYM_START;
      burst.sym1 = SYM_SEND; burst.val1 = DEV_WRITE;
    end else if (op == OP_ACK && phase_r == PH_POLL) begin
      burst.count = 2'd1;
      if (ack_bit) begin
        burst.sym0 = SYM_START;
        burst.sym1 = SYM_SEND; burst.val1 = DEV_WRITE;
      end else begin
        burst.sym0 = SYM_SEND; burst.val0 = addr_r[15:8];
        burst.sym1 = SYM_SEND; burst.val1 = addr_r[7:0];
        phase_nxt = reading_r ? PH_RADDR : PH_WDATA;
      end
    end else if (op == OP_ACK && phase_r == PH_RADDR) begin
      burst.count = 2'd2; burst.sym0 = SYM_START;
      burst.sym1 = SYM_SEND; burst.val1 = DEV_READ;
      burst.sym2 = SYM_RECV;
      phase_nxt = PH_RDATA;
    end else if (op == OP_ACK && phase_r == PH_WPAGE) begin
      burst.count = 2'd1; burst.sym0 = SYM_START;
      burst.sym1 = SYM_SEND; burst.val1 = DEV_WRITE;
      phase_nxt = PH_POLL;
    end else if (op == OP_ACK && phase_r == PH_WDATA) begin
      // drop: acks while streaming data are not checked
      has_burst = 1'b0;
    end else if (op == OP_WDATA && phase_r == PH_WDATA) begin
      burst.sym0 = SYM_SEND; burst.val0 = data;
      addr_nxt = addr_inc;
      if (last_byte) begin
        burst.count = 2'd2; burst.sym1 = SYM_RELEASE; burst.sym2 = SYM_DONE;
        phase_nxt = PH_IDLE;
      end else if (page_end) begin
        burst.count = 2'd1; burst.sym1 = SYM_RELEASE;
        phase_nxt = PH_WPAGE;
      end
    end else if (op == OP_BYTE && phase_r == PH_RDATA) begin
      burst.count = 2'd2; burst.sym0 = SYM_READ; burst.val0 = data;
      addr_nxt = addr_inc;
      if (left_r <= 16'd1) begin
        left_nxt = 16'd0;
        burst.sym1 = SYM_NACK; burst.sym2 = SYM_RELEASE;
        phase_nxt = PH_IDLE;
      end else begin
        left_nxt = left_r - 16'd1;
        burst.sym1 = SYM_ACK; burst.sym2 = SYM_RECV;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/ieps_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
module ieps_queue import ieps_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   wr,
  input  wire burst_t wr_data,
  input  wire logic   rd,
  output burst_t      rd_data,
  output logic        empty,
  output logic        full
);

  localparam int DEPTH = 4;

  burst_t     mem_r [DEPTH];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign empty   = (cnt_r == 3'd0);
  assign full    = (cnt_r == 3'(DEPTH));
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 2'd0; rp_r <= 2'd0; cnt_r <= 3'd0;
    end else begin
      if (wr) wp_r <= wp_r + 2'd1;
      if (rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + 3'(wr) - 3'(rd);
    end
  end

endmodule
`default_nettype wire

/* rtl/core/ieps_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module ieps_back import ieps_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire burst_t head,
  input  wire logic   head_empty,
  output logic        head_pop,
  output logic        out_empty,
  input  wire logic   out_pop,
  output logic [3:0]  out_symbol,
  output logic [7:0]  out_value,
  output logic        out_end_of_run
);

  logic [1:0] idx_r;
  logic       take;

  assign out_empty = head_empty;
  assign take      = out_pop && !head_empty;
  assign head_pop  = take && (idx_r == head.count);
  assign out_end_of_run = (idx_r == head.count);

  always_comb begin
    case (idx_r)
      2'd0:    begin out_symbol = head.sym0; out_value = head.val0; end
      2'd1:    begin out_symbol = head.sym1; out_value = head.val1; end
      default: begin out_symbol = head.sym2; out_value = head.val2; end
    endcase
  end

  // advance through the burst, wrap when its last symbol goes out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= 2'd0;
    end else if (take) begin
      idx_r <= head_pop ? 2'd0 : idx_r + 2'd1;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/i2c_eeprom_page_transfer_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none
// Symbol-level I2C master sequencer for a serial EEPROM. Each accepted item
// is classified combinationally by the front phase machine into a burst
// of one to three bus symbols (start, send, receive, ack/nack, release,
// read data, done, rejected) and pushed into a four-entry burst queue; the
// back end hands the symbols out one per pop, flagging the last of each
// burst with end_of_run. An item is taken every cycle while the queue has
// room; an ack during write data produces no symbols. Writes re-poll the
// device at each PAGE_BYTES boundary.
module i2c_eeprom_page_transfer_sequencer import ieps_pkg::*; #(
  parameter int PAGE_BYTES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [2:0]  in_op,
  input  wire logic [15:0] in_ee_addr,
  input  wire logic [7:0]  in_data,
  input  wire logic        in_last_byte,
  input  wire logic [15:0] in_read_count,
  input  wire logic        in_ack_bit,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [3:0]       out_symbol,
  output logic [7:0]       out_value,
  output logic             out_end_of_run
);

  burst_t burst, head;
  logic   has_burst, take, q_empty, q_pop;

  assign take = in_push && !in_full;

  ieps_front #(.PAGE_BYTES(PAGE_BYTES)) u_front (
    .clk, .rst_n, .take,
    .op(in_op), .ee_addr(in_ee_addr), .data(in_data),
    .last_byte(in_last_byte), .read_count(in_read_count),
    .ack_bit(in_ack_bit), .burst, .has_burst
  );

  ieps_queue u_queue (
    .clk, .rst_n, .wr(take && has_burst), .wr_data(burst),
    .rd(q_pop), .rd_data(head), .empty(q_empty), .full(in_full)
  );

  ieps_back u_back (
    .clk, .rst_n, .head, .head_empty(q_empty), .head_pop(q_pop),
    .out_empty, .out_pop, .out_symbol, .out_value, .out_end_of_run
  );

endmodule
`default_nettype wire
